### hdl/mbp_pkg.sv
package mbp_pkg;

  localparam int INPUT_COUNT         = 2;
  localparam int HIDDEN_COUNT        = 2;
  localparam int OUTPUT_COUNT        = 1;
  localparam int SIGMOID_TABLE_DEPTH = 256;

  localparam int IH_SIZE = (INPUT_COUNT + 1) * HIDDEN_COUNT;
  localparam int HO_SIZE = (HIDDEN_COUNT + 1) * OUTPUT_COUNT;
  localparam int IH_AW   = $clog2(IH_SIZE);
  localparam int HO_AW   = $clog2(HO_SIZE);
  localparam int HID_W   = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int OUT_W   = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
  localparam int MAX_SRC = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT;
  localparam int SRC_W   = $clog2(MAX_SRC + 1);
  localparam int SIG_AW  = $clog2(SIGMOID_TABLE_DEPTH);

  localparam logic [18:0] LR_RESET  = 19'd65536;
  localparam longint      SIG_HALF  = 524288;
  localparam logic [63:0] ONE_Q24   = 64'd16777216;

  localparam logic [1:0] FUNC_INFER = 2'd0;
  localparam logic [1:0] FUNC_TRAIN = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         pattern_bits;
    logic [16:0]        target_value;
    logic               weight_layer;
    logic [7:0]         weight_index;
    logic signed [31:0] weight_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  output_index;
    logic [16:0] net_output;
    logic        last_result;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_MUL_LO, OP_MUL_HI, OP_FH_ADD, OP_FH_ACT, OP_FO_ADD,
    OP_FO_BIAS, OP_FO_ACT, OP_DO_WR, OP_DH_T1, OP_DH_ADD, OP_DH_STORE, OP_UO_A,
    OP_UO_W, OP_UO_BIAS, OP_UH_STEP, OP_UH_W, OP_LOAD
  } dp_op_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_FO, MS_DO, MS_DH1, MS_DH2, MS_UOA, MS_UOW, MS_UH
  } msel_t;

  typedef enum logic [1:0] {SH0, SH16, SH32} shift_t;

  typedef enum logic [1:0] {MPH_LO, MPH_HI, MPH_WR} mph_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_FH_SUM, ST_FH_ACT, ST_FO_MUL, ST_FO_BIAS, ST_FO_ACT,
    ST_DO_MUL, ST_DH_MUL1, ST_DH_MUL2, ST_DH_STORE, ST_UO_MULA, ST_UO_MUL,
    ST_UO_BIAS, ST_UH_MUL, ST_UH_W, ST_LOAD, ST_EMIT, ST_EMIT_ZERO
  } ctl_state_t;

  typedef struct packed {
    dp_op_t           op;
    msel_t            msel;
    logic             first;
    logic             zero;
    logic             last;
    logic [SRC_W-1:0] src;
    logic [HID_W-1:0] hid;
    logic [OUT_W-1:0] out;
    logic [IH_AW-1:0] ih_addr;
    logic [HO_AW-1:0] ho_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // divide by 2^16, round half away from zero
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m >> 16) + {63'b0, m[15]};
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [SIG_AW-1:0] sig_index(input logic signed [31:0] x);
    logic signed [31:0] c;
    logic [19:0]        off;
    if (x < -32'sd524288) c = -32'sd524288;
    else if (x > 32'sd524287) c = 32'sd524287;
    else c = x;
    off = {~c[19], c[18:0]};
    return off[19 -: SIG_AW];
  endfunction

  // restoring division, only used while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] sig_entry(input int i);
    logic [63:0] num;
    logic [63:0] a;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] s;
    longint      xc;
    num  = (64'(2 * i + 1) << 19) / SIGMOID_TABLE_DEPTH;
    xc   = longint'(num) - SIG_HALF;
    a    = (xc < 0) ? 64'(-xc) : 64'(xc);
    f    = a << 5;
    term = ONE_Q24;
    sum  = ONE_Q24;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * f) >> 24, 64'(k));
      sum  = sum + term;
    end
    for (int k = 0; k < 3; k++) begin
      sum = (sum * sum + (ONE_Q24 >> 1)) >> 24;
    end
    s = udiv64(sum * 64'd65536 + ((sum + ONE_Q24) >> 1), sum + ONE_Q24);
    return (xc < 0) ? 17'(64'd65536 - s) : 17'(s);
  endfunction

  typedef logic [16:0] sig_tab_t [SIGMOID_TABLE_DEPTH];
  typedef logic [14:0] dsig_tab_t [SIGMOID_TABLE_DEPTH];

  function automatic sig_tab_t build_sig();
    sig_tab_t t;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) t[i] = sig_entry(i);
    return t;
  endfunction

  // s * (1 - s) for the same bin
  function automatic dsig_tab_t build_dsig();
    dsig_tab_t   t;
    logic [63:0] s;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      s    = 64'(sig_entry(i));
      t[i] = 15'((s * (64'd65536 - s)) >> 16);
    end
    return t;
  endfunction

  localparam sig_tab_t  SIG_TAB  = build_sig();
  localparam dsig_tab_t DSIG_TAB = build_dsig();

endpackage

### hdl/mlp_backprop_train_step_top.sv
// Two-layer sigmoid perceptron with one backpropagation step per training item.
// req channel (valid/ready): one item per handshake. func 0 infers, 1 infers and
// trains toward target_value, 2 loads one weight; any other code just answers.
// rsp channel (valid/ready): one result per output neuron for func 0 and 1, the
// final one flagged by last_result; a single zero result for loads.
// cfg channel (valid/ready, always ready): writes the learning rate (unsigned Q3.16).
// The next item can be accepted in the cycle after the last result is taken. All
// products go through one shared multiplier, each taking two 24x32 passes and a
// write-back, so latency grows with the number of weights.
// One item is in flight at a time; req_ready is high only while idle.
// A stalled result holds its payload until taken, and the next item waits.
// Reset clears all weights to zero and the learning rate to 1.0; the block is
// ready for an item in the first cycle after reset.
module mlp_backprop_train_step_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mbp_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mbp_pkg::rsp_t rsp_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [18:0]   cfg_data
);
  import mbp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_data  (req_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .rsp_data  (rsp_data)
  );

endmodule

### hdl/mbp_ctrl.sv
module mbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  mbp_pkg::dp_stat_t stat,
  output mbp_pkg::dp_cmd_t  cmd
);
  import mbp_pkg::*;

  ctl_state_t       state, state_next;
  mph_t             mph, mph_next;
  logic [SRC_W-1:0] j, j_next;
  logic [HID_W-1:0] h, h_next;
  logic [OUT_W-1:0] o, o_next;
  logic             h_last, o_last, j_in, j_hlast;
  logic [HID_W-1:0] ho_src;

  assign h_last  = (h == HID_W'(HIDDEN_COUNT - 1));
  assign o_last  = (o == OUT_W'(OUTPUT_COUNT - 1));
  assign j_in    = (j == SRC_W'(INPUT_COUNT));
  assign j_hlast = (j == SRC_W'(HIDDEN_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mph   <= MPH_LO;
      j     <= '0;
      h     <= '0;
      o     <= '0;
    end else begin
      state <= state_next;
      mph   <= mph_next;
      j     <= j_next;
      h     <= h_next;
      o     <= o_next;
    end
  end

  assign ho_src = (state == ST_DH_MUL1) ? h : j[HID_W-1:0];

  always_comb begin
    state_next  = state;
    mph_next    = mph;
    j_next      = j;
    h_next      = h;
    o_next      = o;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.op      = OP_NONE;
    cmd.msel    = MS_FO;
    cmd.first   = 1'b0;
    cmd.zero    = 1'b0;
    cmd.last    = 1'b0;
    cmd.src     = j;
    cmd.hid     = h;
    cmd.out     = o;
    cmd.ih_addr = IH_AW'(int'(j) * HIDDEN_COUNT + int'(h));
    cmd.ho_addr = HO_AW'(int'((state == ST_DH_MUL1) ? SRC_W'(ho_src) : j) * OUTPUT_COUNT
                         + int'(o));

    // multiply phases shared by all product states
    case (state)
      ST_FO_MUL, ST_DO_MUL, ST_DH_MUL1, ST_DH_MUL2, ST_UO_MULA, ST_UO_MUL,
      ST_UH_MUL: begin
        case (mph)
          MPH_LO: begin
            cmd.op   = OP_MUL_LO;
            mph_next = MPH_HI;
          end
          MPH_HI: begin
            cmd.op   = OP_MUL_HI;
            mph_next = MPH_WR;
          end
          default: mph_next = MPH_LO;
        endcase
      end
      default: ;
    endcase

    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_CAPTURE;
          j_next     = '0;
          h_next     = '0;
          o_next     = '0;
          mph_next   = MPH_LO;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.func == FUNC_LOAD) state_next = ST_LOAD;
        else if (stat.func == FUNC_INFER || stat.func == FUNC_TRAIN) state_next = ST_FH_SUM;
        else state_next = ST_EMIT_ZERO;
      end
      ST_FH_SUM: begin
        cmd.op    = OP_FH_ADD;
        cmd.first = (j == '0);
        if (j_in) begin
          j_next     = '0;
          state_next = ST_FH_ACT;
        end else begin
          j_next = j + SRC_W'(1);
        end
      end
      ST_FH_ACT: begin
        cmd.op = OP_FH_ACT;
        j_next = '0;
        if (h_last) begin
          h_next     = '0;
          state_next = ST_FO_MUL;
        end else begin
          h_next     = h + HID_W'(1);
          state_next = ST_FH_SUM;
        end
      end
      ST_FO_MUL: begin
        cmd.msel = MS_FO;
        if (mph == MPH_WR) begin
          cmd.op    = OP_FO_ADD;
          cmd.first = (j == '0);
          j_next    = j + SRC_W'(1);
          if (j_hlast) state_next = ST_FO_BIAS;
        end
      end
      ST_FO_BIAS: begin
        cmd.op     = OP_FO_BIAS;
        state_next = ST_FO_ACT;
      end
      ST_FO_ACT: begin
        cmd.op = OP_FO_ACT;
        j_next = '0;
        if (o_last) begin
          o_next     = '0;
          state_next = (stat.func == FUNC_TRAIN) ? ST_DO_MUL : ST_EMIT;
        end else begin
          o_next     = o + OUT_W'(1);
          state_next = ST_FO_MUL;
        end
      end
      ST_DO_MUL: begin
        cmd.msel = MS_DO;
        if (mph == MPH_WR) begin
          cmd.op = OP_DO_WR;
          if (o_last) begin
            o_next     = '0;
            h_next     = '0;
            state_next = ST_DH_MUL1;
          end else begin
            o_next = o + OUT_W'(1);
          end
        end
      end
      ST_DH_MUL1: begin
        cmd.msel = MS_DH1;
        if (mph == MPH_WR) begin
          cmd.op     = OP_DH_T1;
          state_next = ST_DH_MUL2;
        end
      end
      ST_DH_MUL2: begin
        cmd.msel = MS_DH2;
        if (mph == MPH_WR) begin
          cmd.op    = OP_DH_ADD;
          cmd.first = (o == '0);
          if (o_last) begin
            o_next     = '0;
            state_next = ST_DH_STORE;
          end else begin
            o_next     = o + OUT_W'(1);
            state_next = ST_DH_MUL1;
          end
        end
      end
      ST_DH_STORE: begin
        cmd.op = OP_DH_STORE;
        if (h_last) begin
          h_next     = '0;
          o_next     = '0;
          state_next = ST_UO_MULA;
        end else begin
          h_next     = h + HID_W'(1);
          state_next = ST_DH_MUL1;
        end
      end
      ST_UO_MULA: begin
        cmd.msel = MS_UOA;
        if (mph == MPH_WR) begin
          cmd.op     = OP_UO_A;
          j_next     = '0;
          state_next = ST_UO_MUL;
        end
      end
      ST_UO_MUL: begin
        cmd.msel = MS_UOW;
        if (mph == MPH_WR) begin
          cmd.op = OP_UO_W;
          j_next = j + SRC_W'(1);
          if (j_hlast) state_next = ST_UO_BIAS;
        end
      end
      ST_UO_BIAS: begin
        cmd.op = OP_UO_BIAS;
        j_next = '0;
        if (o_last) begin
          o_next     = '0;
          h_next     = '0;
          state_next = ST_UH_MUL;
        end else begin
          o_next     = o + OUT_W'(1);
          state_next = ST_UO_MULA;
        end
      end
      ST_UH_MUL: begin
        cmd.msel = MS_UH;
        if (mph == MPH_WR) begin
          cmd.op     = OP_UH_STEP;
          j_next     = '0;
          state_next = ST_UH_W;
        end
      end
      ST_UH_W: begin
        cmd.op = OP_UH_W;
        if (j_in) begin
          j_next = '0;
          if (h_last) begin
            h_next     = '0;
            state_next = ST_EMIT;
          end else begin
            h_next     = h + HID_W'(1);
            state_next = ST_UH_MUL;
          end
        end else begin
          j_next = j + SRC_W'(1);
        end
      end
      ST_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = ST_EMIT_ZERO;
      end
      ST_EMIT: begin
        rsp_valid = 1'b1;
        cmd.last  = o_last;
        if (rsp_ready) begin
          if (o_last) begin
            o_next     = '0;
            state_next = ST_IDLE;
          end else begin
            o_next = o + OUT_W'(1);
          end
        end
      end
      ST_EMIT_ZERO: begin
        rsp_valid = 1'b1;
        cmd.zero  = 1'b1;
        cmd.last  = 1'b1;
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hdl/mbp_datapath.sv
module mbp_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mbp_pkg::dp_cmd_t  cmd,
  output mbp_pkg::dp_stat_t stat,
  input  mbp_pkg::req_t     req_data,
  input  logic              cfg_valid,
  input  logic [18:0]       cfg_data,
  output mbp_pkg::rsp_t     rsp_data
);
  import mbp_pkg::*;

  req_t               req_q;
  logic [18:0]        lr;
  logic signed [31:0] ih_w [IH_SIZE];
  logic signed [31:0] ho_w [HO_SIZE];
  logic [16:0]        act [HIDDEN_COUNT];
  logic [14:0]        dact [HIDDEN_COUNT];
  logic [16:0]        net [OUTPUT_COUNT];
  logic [14:0]        dnet [OUTPUT_COUNT];
  logic signed [33:0] deltao [OUTPUT_COUNT];
  logic signed [47:0] deltah [HIDDEN_COUNT];
  logic signed [47:0] t1;
  logic signed [39:0] areg;
  logic signed [39:0] step;
  logic signed [63:0] acc;

  // two-pass multiplier: low 24 bits of |A| then high 24 bits
  logic [79:0]        p;
  logic [23:0]        a_hi;
  logic [31:0]        b_l;
  logic               neg;
  shift_t             sh;

  logic signed [31:0] ih_rd, ho_rd;
  logic signed [63:0] ih64, ho64, step64, areg64;
  logic [16:0]        act_j, net_o;
  logic [14:0]        dact_h, dnet_o;
  logic signed [33:0] deltao_o;
  logic signed [47:0] deltah_h;
  logic signed [17:0] diff;
  logic               pbit, is_bias_in;
  logic [7:0]         pshift;

  logic signed [48:0] opa;
  logic signed [32:0] opb;
  shift_t             sh_c;
  logic [48:0]        a_abs;
  logic [32:0]        b_abs;
  logic [55:0]        lo_prod, hi_prod;
  logic [79:0]        ps;
  logic               rb;
  logic [63:0]        mag;
  logic signed [63:0] mres, base, rnd_acc, rnd_a, rnd_m;
  logic signed [31:0] sat_h, sat_o;
  logic [SIG_AW-1:0]  idx_h, idx_o;

  assign stat.func = req_q.func;

  assign ih_rd    = ih_w[cmd.ih_addr];
  assign ho_rd    = ho_w[cmd.ho_addr];
  assign ih64     = {{32{ih_rd[31]}}, ih_rd};
  assign ho64     = {{32{ho_rd[31]}}, ho_rd};
  assign step64   = {{24{step[39]}}, step};
  assign areg64   = {{24{areg[39]}}, areg};
  assign act_j    = act[cmd.src[HID_W-1:0]];
  assign dact_h   = dact[cmd.hid];
  assign net_o    = net[cmd.out];
  assign dnet_o   = dnet[cmd.out];
  assign deltao_o = deltao[cmd.out];
  assign deltah_h = deltah[cmd.hid];
  assign diff     = $signed({1'b0, req_q.target_value}) - $signed({1'b0, net_o});

  assign pshift     = req_q.pattern_bits >> cmd.src;
  assign pbit       = pshift[0];
  assign is_bias_in = (cmd.src == SRC_W'(INPUT_COUNT));

  always_comb begin
    opa  = {{17{ho_rd[31]}}, ho_rd};
    opb  = {16'b0, act_j};
    sh_c = SH0;
    case (cmd.msel)
      MS_FO: begin
        opa  = {{17{ho_rd[31]}}, ho_rd};
        opb  = {16'b0, act_j};
        sh_c = SH0;
      end
      MS_DO: begin
        opa  = {{31{diff[17]}}, diff};
        opb  = {18'b0, dnet_o};
        sh_c = SH0;
      end
      MS_DH1: begin
        opa  = {{17{ho_rd[31]}}, ho_rd};
        opb  = deltao_o[32:0];
        sh_c = SH16;
      end
      MS_DH2: begin
        opa  = {t1[47], t1};
        opb  = {18'b0, dact_h};
        sh_c = SH16;
      end
      MS_UOA: begin
        opa  = {{15{deltao_o[33]}}, deltao_o};
        opb  = {14'b0, lr};
        sh_c = SH16;
      end
      MS_UOW: begin
        opa  = {{9{areg[39]}}, areg};
        opb  = {16'b0, act_j};
        sh_c = SH32;
      end
      MS_UH: begin
        opa  = {deltah_h[47], deltah_h};
        opb  = {14'b0, lr};
        sh_c = SH16;
      end
      default: ;
    endcase
  end

  assign a_abs   = opa[48] ? 49'(-opa) : 49'(opa);
  assign b_abs   = opb[32] ? 33'(-opb) : 33'(opb);
  assign lo_prod = a_abs[23:0] * b_abs[31:0];
  assign hi_prod = a_hi * b_l;

  always_comb begin
    ps = p;
    rb = 1'b0;
    case (sh)
      SH0: begin
        ps = p;
        rb = 1'b0;
      end
      SH16: begin
        ps = p >> 16;
        rb = p[15];
      end
      SH32: begin
        ps = p >> 32;
        rb = p[31];
      end
      default: ;
    endcase
  end

  assign mag     = ps[63:0] + {63'b0, rb};
  assign mres    = neg ? -$signed(mag) : $signed(mag);
  assign base    = cmd.first ? 64'sd0 : acc;
  assign rnd_acc = rnd16(acc);
  assign rnd_a   = rnd16(areg64);
  assign rnd_m   = rnd16(mres);
  assign sat_h   = sat32(acc);
  assign sat_o   = sat32(rnd_acc);
  assign idx_h   = sig_index(sat_h);
  assign idx_o   = sig_index(sat_o);

  always_ff @(posedge clk) begin
    if (rst) begin
      lr <= LR_RESET;
      for (int i = 0; i < IH_SIZE; i++) ih_w[i] <= '0;
      for (int i = 0; i < HO_SIZE; i++) ho_w[i] <= '0;
    end else begin
      if (cfg_valid) lr <= cfg_data;
      case (cmd.op)
        OP_UO_W:    ho_w[cmd.ho_addr] <= sat32(ho64 + mres);
        OP_UO_BIAS: ho_w[cmd.ho_addr] <= sat32(ho64 - rnd_a);
        OP_UH_W: begin
          if (is_bias_in) ih_w[cmd.ih_addr] <= sat32(ih64 - step64);
          else if (pbit) ih_w[cmd.ih_addr] <= sat32(ih64 + step64);
        end
        OP_LOAD: begin
          if (!req_q.weight_layer && req_q.weight_index < 8'(IH_SIZE))
            ih_w[req_q.weight_index[IH_AW-1:0]] <= req_q.weight_value;
          if (req_q.weight_layer && req_q.weight_index < 8'(HO_SIZE))
            ho_w[req_q.weight_index[HO_AW-1:0]] <= req_q.weight_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: req_q <= req_data;
      OP_MUL_LO: begin
        p    <= {24'b0, lo_prod};
        a_hi <= a_abs[47:24];
        b_l  <= b_abs[31:0];
        neg  <= opa[48] ^ opb[32];
        sh   <= sh_c;
      end
      OP_MUL_HI: p <= p + {hi_prod, 24'b0};
      OP_FH_ADD: begin
        if (is_bias_in) acc <= base - ih64;
        else if (pbit) acc <= base + ih64;
        else acc <= base;
      end
      OP_FH_ACT: begin
        act[cmd.hid]  <= SIG_TAB[idx_h];
        dact[cmd.hid] <= DSIG_TAB[idx_h];
      end
      OP_FO_ADD:  acc <= base + mres;
      OP_FO_BIAS: acc <= acc - (ho64 <<< 16);
      OP_FO_ACT: begin
        net[cmd.out]  <= SIG_TAB[idx_o];
        dnet[cmd.out] <= DSIG_TAB[idx_o];
      end
      OP_DO_WR:    deltao[cmd.out] <= mres[33:0];
      OP_DH_T1:    t1 <= mres[47:0];
      OP_DH_ADD:   acc <= base + mres;
      OP_DH_STORE: deltah[cmd.hid] <= acc[47:0];
      OP_UO_A:     areg <= mres[39:0];
      OP_UH_STEP:  step <= rnd_m[39:0];
      default: ;
    endcase
  end

  assign rsp_data.output_index = 2'(cmd.out);
  assign rsp_data.net_output   = cmd.zero ? 17'd0 : net_o;
  assign rsp_data.last_result  = cmd.last;

endmodule
